// File: rtl/box_blur_3x3_edge_aware_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur
// Shared concurrent assertion forms used by the blur checker.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define BB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after reset is applied.
`define BB_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bblur_pkg.sv
// ----------------------------------------------------------------------------
// Box blur package
// Widths, register indexes and divider constants shared by the blur files.
// ----------------------------------------------------------------------------
package bblur_pkg;

    localparam int MAX_LINE    = 2048;
    localparam int LINE_AW     = $clog2(MAX_LINE);
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int LINE_W      = 2 * PIX_W;
    localparam int ROW_W       = 16;
    localparam int COL_W       = 11;
    localparam int WIDTH_W     = 12;
    localparam int CFG_W       = 16;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int MEAN_IN_W   = SUM_W + 1;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int S_DATA_W    = PIX_W;
    localparam int M_FIELDS_W  = PIX_W + ROW_W + COL_W;
    localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_DATA_W - M_FIELDS_W;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = ROW_W'(480);

    typedef logic [0:0] t_cfg_addr;
    localparam t_cfg_addr REG_IMAGE_WIDTH  = 1'b0;
    localparam t_cfg_addr REG_IMAGE_HEIGHT = 1'b1;

    // Reciprocal of twice the pixel count, scaled by 2^RECIP_SHIFT and rounded up.
    // Exact for every rounded mean of up to nine 8-bit pixels.
    function automatic logic [RECIP_W-1:0] mean_recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        unique case (cnt)
            CNT_W'(1): r = RECIP_W'(131072);
            CNT_W'(2): r = RECIP_W'(65536);
            CNT_W'(3): r = RECIP_W'(43691);
            CNT_W'(4): r = RECIP_W'(32768);
            CNT_W'(6): r = RECIP_W'(21846);
            CNT_W'(9): r = RECIP_W'(14564);
            default:   r = RECIP_W'(131072);
        endcase
        return r;
    endfunction

endpackage

// File: rtl/bblur_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bblur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/box_blur_3x3_edge_aware.sv
// ----------------------------------------------------------------------------
// Edge-aware 3x3 box blur
// RGB pixels in raster order; emits rounded per-channel neighborhood means.
// ----------------------------------------------------------------------------
// An accepted pixel reads and updates the line memory (IDLE, LOAD), then
// each result it releases (zero to four) uses the one shared sum and
// reciprocal-multiply datapath (SUM, DIV); input waits for the last result.
// The two previous lines sit in one 2048 x 48 memory with no clearing pass:
// entries are only used once the frame has written them. Writing either
// register restarts the frame at row 0, column 0.
module box_blur_3x3_edge_aware
    import bblur_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_addr           i_cfg_addr,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // pixel_red, pixel_green, pixel_blue
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // blur_red, blur_green, blur_blue, out_row, out_column, zero pad
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // last_of_run
    output logic                m_axis_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_DIV  = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        K_UP_LEFT,
        K_UP,
        K_LEFT,
        K_HERE
    } t_kind;

    typedef logic [PIX_W-1:0] t_pix;

    t_state                r_state, n_state;
    logic [WIDTH_W-1:0]    r_width;
    logic [ROW_W-1:0]      r_height;
    logic [ROW_W-1:0]      r_row;
    logic [LINE_AW-1:0]    r_col;
    t_pix                  r_px;
    t_pix                  r_win [3][3];
    logic [ROW_W-1:0]      r_cr;
    logic [LINE_AW-1:0]    r_cc;
    logic [3:0]            r_pend, n_pend;
    logic [SUM_W-1:0]      r_sum [3];
    logic [CNT_W-1:0]      r_cnt;
    logic [RECIP_W-1:0]    r_recip;
    logic [ROW_W-1:0]      r_orow;
    logic [COL_W-1:0]      r_ocol;
    logic                  r_olast;
    logic                  r_m_valid;
    logic [M_DATA_W-1:0]   r_m_data;
    logic                  r_m_last;

    logic                  s_acc;
    logic                  out_free;
    logic [LINE_AW-1:0]    last_col;
    logic [ROW_W-1:0]      last_row;
    logic [LINE_W-1:0]     ram_rdata;
    t_pix                  ram_older;
    t_pix                  ram_newer;
    logic                  ld_lastcol;
    logic                  ld_lastrow;
    logic [3:0]            ld_pend;
    t_kind                 kind;
    logic [3:0]            pend_low;
    logic [2:0]            row_ok;
    logic [2:0]            col_ok;
    logic [SUM_W-1:0]      sum [3];
    logic [CNT_W-1:0]      cnt;
    logic [CNT_W-1:0]      nrows;
    logic [CNT_W-1:0]      ncols;
    logic [ROW_W-1:0]      sum_row;
    logic [LINE_AW-1:0]    sum_col;
    logic [MEAN_IN_W-1:0]  mean_in [3];
    logic [MEAN_IN_W+RECIP_W-1:0] prod [3];
    logic [CHAN_W-1:0]     mean [3];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    always_comb begin
        priority if (r_width == '0) begin
            last_col = '0;
        end else if (int'(r_width) > MAX_LINE) begin
            last_col = LINE_AW'(MAX_LINE - 1);
        end else begin
            last_col = LINE_AW'(r_width - 1'b1);
        end
        last_row = (r_height == '0) ? '0 : r_height - 1'b1;
    end

    bblur_ram #(
        .WIDTH(LINE_W),
        .DEPTH(MAX_LINE)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (r_state == ST_LOAD),
        .i_waddr(r_col),
        .i_wdata({ram_newer, r_px}),
        .i_re   (s_acc),
        .i_raddr(r_col),
        .o_rdata(ram_rdata)
    );

    assign ram_older = ram_rdata[LINE_W-1:PIX_W];
    assign ram_newer = ram_rdata[PIX_W-1:0];

    assign ld_lastcol = (r_col == last_col);
    assign ld_lastrow = (r_row == last_row);
    assign ld_pend    = {ld_lastrow && ld_lastcol, ld_lastrow && (r_col != '0),
                         (r_row != '0) && ld_lastcol, (r_row != '0) && (r_col != '0)};

    // Results leave in raster order: the lowest pending bit goes first.
    always_comb begin
        pend_low = r_pend & (~r_pend + 4'd1);
        n_pend   = r_pend & ~pend_low;
        priority if (r_pend[0]) begin
            kind = K_UP_LEFT;
        end else if (r_pend[1]) begin
            kind = K_UP;
        end else if (r_pend[2]) begin
            kind = K_LEFT;
        end else begin
            kind = K_HERE;
        end
    end

    always_comb begin
        row_ok[0] = ((kind == K_UP_LEFT) || (kind == K_UP)) && (r_cr > ROW_W'(1));
        row_ok[1] = (r_cr != '0);
        row_ok[2] = 1'b1;
        col_ok[0] = ((kind == K_UP_LEFT) || (kind == K_LEFT)) && (r_cc > LINE_AW'(1));
        col_ok[1] = (r_cc != '0);
        col_ok[2] = 1'b1;
        nrows = CNT_W'(row_ok[0]) + CNT_W'(row_ok[1]) + CNT_W'(row_ok[2]);
        ncols = CNT_W'(col_ok[0]) + CNT_W'(col_ok[1]) + CNT_W'(col_ok[2]);
        cnt   = CNT_W'(nrows * ncols);
        for (int c = 0; c < 3; c++) begin
            sum[c] = '0;
            for (int k = 0; k < 3; k++) begin
                for (int m = 0; m < 3; m++) begin
                    if (row_ok[k] && col_ok[m]) begin
                        sum[c] = sum[c] + SUM_W'(r_win[k][m][PIX_W-1-c*CHAN_W -: CHAN_W]);
                    end
                end
            end
        end
        sum_row = ((kind == K_UP_LEFT) || (kind == K_UP)) ? r_cr - 1'b1 : r_cr;
        sum_col = ((kind == K_UP_LEFT) || (kind == K_LEFT)) ? r_cc - 1'b1 : r_cc;
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mean_in[c] = {r_sum[c], 1'b0} + MEAN_IN_W'(r_cnt);
            prod[c]    = (MEAN_IN_W+RECIP_W)'(mean_in[c]) * (MEAN_IN_W+RECIP_W)'(r_recip);
            mean[c]    = prod[c][RECIP_SHIFT +: CHAN_W];
        end
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = s_acc ? ST_LOAD : ST_IDLE;
            ST_LOAD: n_state = (ld_pend != '0) ? ST_SUM : ST_IDLE;
            ST_SUM:  n_state = ST_DIV;
            ST_DIV: begin
                if (!out_free) begin
                    n_state = ST_DIV;
                end else if (r_pend != '0) begin
                    n_state = ST_SUM;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_row     <= '0;
            r_col     <= '0;
            r_pend    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata[ROW_W-1:0];
                    default:          r_width  <= r_width;
                endcase
                r_row <= '0;
                r_col <= '0;
            end else if (r_state == ST_LOAD) begin
                if (ld_lastcol) begin
                    r_col <= '0;
                    r_row <= ld_lastrow ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (r_state == ST_LOAD) begin
                r_pend <= ld_pend;
            end else if (r_state == ST_SUM) begin
                r_pend <= n_pend;
            end
            if ((r_state == ST_DIV) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_px <= {s_axis_tdata[CHAN_W-1:0], s_axis_tdata[2*CHAN_W-1:CHAN_W],
                     s_axis_tdata[3*CHAN_W-1:2*CHAN_W]};
        end
        if (i_cfg_we) begin
            for (int k = 0; k < 3; k++) begin
                for (int m = 0; m < 3; m++) begin
                    r_win[k][m] <= '0;
                end
            end
        end else if (r_state == ST_LOAD) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= ram_older;
            r_win[1][2] <= ram_newer;
            r_win[2][2] <= r_px;
            r_cr        <= r_row;
            r_cc        <= r_col;
        end
        if (r_state == ST_SUM) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= sum[c];
            end
            r_cnt   <= cnt;
            r_recip <= mean_recip(cnt);
            r_orow  <= sum_row;
            r_ocol  <= COL_W'(sum_col);
            r_olast <= (n_pend == '0);
        end
        if ((r_state == ST_DIV) && out_free) begin
            r_m_data <= {{M_PAD_W{1'b0}}, r_ocol, r_orow, mean[2], mean[1], mean[0]};
            r_m_last <= r_olast;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

// File: rtl/bblur_checker.sv
// ----------------------------------------------------------------------------
// Box blur port checker
// Watches the blur's ports for ordering and handshake slips; bound to the top.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_aware_macros.svh"

module bblur_checker
    import bblur_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_we,
    input t_cfg_addr           i_cfg_addr,
    input logic [CFG_W-1:0]    i_cfg_wdata,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [S_DATA_W-1:0] s_axis_tdata,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tlast
);

    logic cfg_seen;
    logic pix_seen;

    assign cfg_seen = i_cfg_we && (i_cfg_addr == REG_IMAGE_WIDTH || i_cfg_wdata != '0);
    assign pix_seen = s_axis_tvalid && (s_axis_tdata != '0 || cfg_seen || !cfg_seen);

    `BB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
    `BB_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, pix_seen && s_axis_tready, !s_axis_tready, "pixel taken while previous pixel in work")
    `BB_ASSERT_NOW(a_run_blocks_input, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "pixel taken before its run of results ended")
    `BB_ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n, !m_axis_tvalid, "result valid after reset")

endmodule

bind box_blur_3x3_edge_aware bblur_checker u_bblur_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_addr   (i_cfg_addr),
    .i_cfg_wdata  (i_cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the edge-aware 3x3 box blur
// Streams RGB frames of many shapes into the block and predicts every blurred
// pixel, with its row, column and end-of-run flag, from an in-bench copy of
// the line buffers and the 3x3 window. Results are checked in order; both stream
// sides pause at random but for the tail frames. Geometry changes only while idle.
// ----------------------------------------------------------------------------
module testbench
    import bblur_pkg::*;
();

    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 250;
    localparam int TAIL_ITEMS     = 50;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } t_blur;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    t_cfg_addr           i_cfg_addr;
    logic [CFG_W-1:0]    i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // pixel_red, pixel_green, pixel_blue
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // blur_red, blur_green, blur_blue, out_row, out_column, zero pad
    logic [M_DATA_W-1:0] m_axis_tdata;
    // last_of_run
    logic                m_axis_tlast;

    box_blur_3x3_edge_aware dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Bench copy of the blur state. Pixels are packed red, green, blue from the top.
    logic [PIX_W-1:0]   older_px [MAX_LINE];
    logic [PIX_W-1:0]   newer_px [MAX_LINE];
    logic [PIX_W-1:0]   win [9];
    int                 pos_row;
    int                 pos_col;
    logic [WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;

    t_blur pending_blurs[$];
    int    mismatches = 0;
    bit    idling_on = 1'b1;
    int    stall_left = 0;
    int    quiet_cycles = 0;

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_LINE) return MAX_LINE;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        if (height_reg == 0) return 1;
        return int'(height_reg);
    endfunction

    function automatic t_blur neighborhood_mean(int rr, int cc, int cur_r, int cur_c,
                                                int w, int h);
        int    sum_r, sum_g, sum_b, cnt, ar, ac, k, m;
        t_blur res;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                ar = rr + dr;
                ac = cc + dc;
                k = ar - (cur_r - 2);
                m = ac - (cur_c - 2);
                if (ar < 0 || ar >= h || ac < 0 || ac >= w) continue;
                if (k < 0 || k > 2 || m < 0 || m > 2) continue;
                sum_r += win[k*3+m][23:16];
                sum_g += win[k*3+m][15:8];
                sum_b += win[k*3+m][7:0];
                cnt++;
            end
        end
        if (cnt == 0) cnt = 1;
        res.red = 8'((2 * sum_r + cnt) / (2 * cnt));
        res.green = 8'((2 * sum_g + cnt) / (2 * cnt));
        res.blue = 8'((2 * sum_b + cnt) / (2 * cnt));
        res.row = 16'(rr);
        res.col = 11'(cc);
        res.last = 1'b0;
        return res;
    endfunction

    task automatic predict_pixel(input logic [PIX_W-1:0] rgb);
        int               w, h, cur_r, cur_c;
        logic [PIX_W-1:0] above2, above1;
        t_blur            found[$];
        t_blur            one;
        bit               lastcol, lastrow;
        w = eff_width();
        h = eff_height();
        cur_r = pos_row;
        cur_c = pos_col;
        above2 = older_px[cur_c];
        above1 = newer_px[cur_c];
        for (int k = 0; k < 3; k++) begin
            win[k*3] = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = above2;
        win[5] = above1;
        win[8] = rgb;
        older_px[cur_c] = above1;
        newer_px[cur_c] = rgb;
        lastcol = (cur_c == w - 1);
        lastrow = (cur_r == h - 1);
        if (cur_r >= 1 && cur_c >= 1)
            found.push_back(neighborhood_mean(cur_r - 1, cur_c - 1, cur_r, cur_c, w, h));
        if (cur_r >= 1 && lastcol)
            found.push_back(neighborhood_mean(cur_r - 1, cur_c, cur_r, cur_c, w, h));
        if (lastrow && cur_c >= 1)
            found.push_back(neighborhood_mean(cur_r, cur_c - 1, cur_r, cur_c, w, h));
        if (lastrow && lastcol)
            found.push_back(neighborhood_mean(cur_r, cur_c, cur_r, cur_c, w, h));
        foreach (found[i]) begin
            one = found[i];
            one.last = (i == found.size() - 1);
            pending_blurs.push_back(one);
        end
        if (lastcol) begin
            pos_col = 0;
            pos_row = lastrow ? 0 : cur_r + 1;
        end else begin
            pos_col = cur_c + 1;
        end
    endtask

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] px;
        px = PIX_W'($urandom);
        for (int ch = 0; ch < 3; ch++) begin
            if ($urandom_range(0, 7) == 0) px[ch*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return px;
    endfunction

    // Pixel in stream order: red in the low byte.
    task automatic send_pixel(input logic [S_DATA_W-1:0] px);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_pixel({px[7:0], px[15:8], px[23:16]});
    endtask

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++) send_pixel(random_pixel());
    endtask

    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_blurs.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr addr, input logic [CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (addr == REG_IMAGE_WIDTH) width_reg = value[WIDTH_W-1:0];
        else height_reg = value;
        pos_row = 0;
        pos_col = 0;
        foreach (win[i]) win[i] = '0;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_until_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic test_reset_geometry();
        send_random_pixels(24);
    endtask

    task automatic test_channel_extremes();
        logic [S_DATA_W-1:0] pattern [18] = '{
            24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000,
            24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
            24'h55AA55, 24'hAA55AA, 24'h010101, 24'hFEFEFE, 24'h7F807F, 24'h80FF01
        };
        set_geometry(16'd3, 16'd3);
        foreach (pattern[i]) send_pixel(pattern[i]);
    endtask

    task automatic test_small_shapes();
        set_geometry(16'd0, 16'd1);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        set_geometry(16'd2, 16'd0);
        send_pixel(24'hFF00FF);
        send_pixel(24'h00FF01);
        set_geometry(16'd1, 16'd3);
        send_random_pixels(3);
        set_geometry(16'd2, 16'd2);
        send_random_pixels(4);
    endtask

    task automatic test_register_restart();
        set_geometry(16'd4, 16'd3);
        send_random_pixels(6);
        wait_until_idle();
        // Bits above the width register are dropped.
        write_reg(REG_IMAGE_WIDTH, 16'hF004);
        send_random_pixels(12);
        send_random_pixels(5);
        wait_until_idle();
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        send_random_pixels(12);
    endtask

    task automatic test_widest_line();
        set_geometry(16'h0FFF, 16'd1);
        send_random_pixels(24);
    endtask

    task automatic test_tallest_frame();
        set_geometry(16'd3, 16'hFFFF);
        send_random_pixels(15);
        set_geometry(16'd1, 16'hFFFF);
        send_random_pixels(8);
    endtask

    task automatic test_random_frames(input int target);
        int sent, w, h, pick, frames, area, part;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                w = $urandom_range(1, 8);
                h = $urandom_range(0, 6);
            end else if (pick < 19) begin
                w = $urandom_range(9, 24);
                h = $urandom_range(0, 6);
            end else begin
                w = $urandom_range(49, 96);
                h = $urandom_range(0, 1);
            end
            set_geometry(CFG_W'(w), CFG_W'(h));
            area = w * ((h == 0) ? 1 : h);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames && sent < target; f++) begin
                if (area > 1 && $urandom_range(0, 9) == 0) begin
                    part = $urandom_range(1, area - 1);
                    send_random_pixels(part);
                    sent += part;
                    break;
                end
                send_random_pixels(area);
                sent += area;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_blur got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.red = m_axis_tdata[7:0];
            got.green = m_axis_tdata[15:8];
            got.blue = m_axis_tdata[23:16];
            got.row = m_axis_tdata[39:24];
            got.col = m_axis_tdata[50:40];
            got.last = m_axis_tlast;
            if (pending_blurs.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: rgb %h %h %h row %0d col %0d last %b",
                             got.red, got.green, got.blue, got.row, got.col, got.last);
                mismatches++;
            end else begin
                want = pending_blurs.pop_front();
                if (got !== want) begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: expected rgb %h %h %h row %0d col %0d last %b, %s",
                                 want.red, want.green, want.blue, want.row, want.col,
                                 want.last,
                                 $sformatf("got rgb %h %h %h row %0d col %0d last %b",
                                           got.red, got.green, got.blue, got.row,
                                           got.col, got.last));
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= REG_IMAGE_WIDTH;
        i_cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        pos_row = 0;
        pos_col = 0;
        foreach (older_px[i]) older_px[i] = '0;
        foreach (newer_px[i]) newer_px[i] = '0;
        foreach (win[i]) win[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_channel_extremes();
        test_small_shapes();
        test_register_restart();
        test_widest_line();
        test_tallest_frame();
        test_random_frames(RANDOM_ITEMS);
        idling_on = 1'b0;
        test_random_frames(TAIL_ITEMS);

        wait_until_idle();
        if (mismatches == 0 && pending_blurs.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
